// ===== rtl/core/tbm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbm_pkg
// Shared types, constants and helpers of the triple-buffer manager.
// ----------------------------------------------------------------------------

package tbm_pkg;

	localparam int CHANNELS_PER_DIRECTION = 32;
	localparam int TABLE_DEPTH            = 2 * CHANNELS_PER_DIRECTION;
	localparam int TIDX_W                 = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam int ADDR_W     = 18;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_COPY_SIZE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEADER    = 1'd1;

	// operation codes
	localparam logic [1:0] FUNC_SETUP    = 2'd0;
	localparam logic [1:0] FUNC_RX_WRITE = 2'd1;
	localparam logic [1:0] FUNC_TX_READ  = 2'd2;

	// initial buffer roles after setup
	localparam logic [1:0] BUF_READ_INIT  = 2'd0;
	localparam logic [1:0] BUF_WRITE_INIT = 2'd1;
	localparam logic [1:0] BUF_CLEAN_INIT = 2'd2;

	localparam logic [15:0] TOTAL_MAX = 16'hFFFF;

	typedef struct packed {
		logic [15:0] offset;
		logic [1:0]  rd;
		logic [1:0]  wr;
		logic [1:0]  cl;
		logic        flag;
	} entry_t;

	typedef struct packed {
		logic [1:0]        buffer_index;
		logic [ADDR_W-1:0] byte_address;
		logic [15:0]       channel_offset;
		logic [15:0]       running_total;
		logic              fresh_data;
	} result_t;

	// header + idx * copy + offset, modulo 2^18
	function automatic logic [ADDR_W-1:0] buf_addr(
		input logic [1:0]  idx,
		input logic [15:0] off,
		input logic [15:0] copy_size,
		input logic [11:0] header
	);
		logic [ADDR_W-1:0] prod;
		prod = (idx[1] ? {1'b0, copy_size, 1'b0} : '0)
			+ (idx[0] ? {2'b00, copy_size} : '0);
		return prod + {6'd0, header} + {2'b00, off};
	endfunction

endpackage

// ===== rtl/core/tbm_entry_update.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbm_entry_update
// Next table entry, next running total and result for one transaction.
// ----------------------------------------------------------------------------

module tbm_entry_update (
	input  logic [1:0]       func,
	input  logic             active,
	input  tbm_pkg::entry_t  entry_in,
	input  logic [15:0]      acc,
	input  logic [15:0]      channel_size,
	input  logic [15:0]      copy_size,
	input  logic [11:0]      header,
	output tbm_pkg::entry_t  entry_out,
	output logic [15:0]      acc_next,
	output tbm_pkg::result_t res
);

	logic [16:0] sum;
	logic [1:0]  tx_idx;

	assign sum    = {1'b0, acc} + {1'b0, channel_size};
	assign tx_idx = entry_in.flag ? entry_in.cl : entry_in.rd;

	always_comb begin
		entry_out = entry_in;
		acc_next  = acc;
		res       = '0;
		res.running_total = acc;
		if (active) begin
			case (func)
				tbm_pkg::FUNC_SETUP: begin
					entry_out.offset = acc;
					entry_out.rd     = tbm_pkg::BUF_READ_INIT;
					entry_out.wr     = tbm_pkg::BUF_WRITE_INIT;
					entry_out.cl     = tbm_pkg::BUF_CLEAN_INIT;
					entry_out.flag   = 1'b0;
					acc_next = sum[16] ? tbm_pkg::TOTAL_MAX : sum[15:0];
					res.channel_offset = acc;
					res.running_total  = acc_next;
				end
				tbm_pkg::FUNC_RX_WRITE: begin
					// report the write buffer, then hand it over as clean
					res.buffer_index   = entry_in.wr;
					res.channel_offset = entry_in.offset;
					res.byte_address   = tbm_pkg::buf_addr(entry_in.wr, entry_in.offset,
						copy_size, header);
					entry_out.wr   = entry_in.cl;
					entry_out.cl   = entry_in.wr;
					entry_out.flag = 1'b1;
				end
				tbm_pkg::FUNC_TX_READ: begin
					// pick up the clean buffer first when new data is pending
					if (entry_in.flag) begin
						entry_out.rd   = entry_in.cl;
						entry_out.cl   = entry_in.rd;
						entry_out.flag = 1'b0;
					end
					res.fresh_data     = entry_in.flag;
					res.buffer_index   = tx_idx;
					res.channel_offset = entry_in.offset;
					res.byte_address   = tbm_pkg::buf_addr(tx_idx, entry_in.offset,
						copy_size, header);
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/multichannel_triple_buffer_manager.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_triple_buffer_manager
// Per-channel triple-buffer index table for receive and transmit channels.
// ----------------------------------------------------------------------------
//
//  channel   signals                                         direction
//  -------   ---------------------------------------------   ---------
//  cfg       cfg_we, cfg_index, cfg_data                     in
//  in        in_valid/in_stall, func, is_transmit,           in
//            channel, channel_size
//  out       out_valid/out_stall, buffer_index,              out
//            byte_address, channel_offset, running_total,
//            fresh_data
//
//  one transaction per cycle while in_stall is low; a result passes the stage-1 and
//  output registers; the channel table read is registered at accept; the entry update
//  and address sum run in stage 1, with a bypass for back-to-back hits on one entry
//  reset clears the running total, the registers and the pipeline; table
//  entries are undefined until set up
//  in_stall rises only when the output register is full and stalled
//

module multichannel_triple_buffer_manager (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [tbm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tbm_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [1:0]                     func,
	input  logic                           is_transmit,
	input  logic [4:0]                     channel,
	input  logic [15:0]                    channel_size,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [1:0]                     buffer_index,
	output logic [tbm_pkg::ADDR_W-1:0]     byte_address,
	output logic [15:0]                    channel_offset,
	output logic [15:0]                    running_total,
	output logic                           fresh_data
);

	logic [15:0] copy_size_q;
	logic [11:0] header_q;
	logic [15:0] acc_q;

	tbm_pkg::entry_t table_mem [tbm_pkg::TABLE_DEPTH];

	logic                        s1_valid_q;
	logic [1:0]                  func_s1;
	logic                        active_s1;
	logic [tbm_pkg::TIDX_W-1:0]  tidx_s1;
	logic [15:0]                 size_s1;
	tbm_pkg::entry_t             rd_s1;
	logic                        byp_hit_s1;
	tbm_pkg::entry_t             byp_data_s1;

	logic             out_valid_q;
	tbm_pkg::result_t res_q;

	logic                       in_fire;
	logic                       s1_adv;
	logic                       in_dir;
	logic                       in_active;
	logic [tbm_pkg::TIDX_W-1:0] in_tidx;
	logic                       wr_en;
	tbm_pkg::entry_t            entry_cur;
	tbm_pkg::entry_t            entry_new;
	logic [15:0]                acc_next;
	tbm_pkg::result_t           res_d;

	assign s1_adv   = !out_valid_q || !out_stall;
	assign in_stall = s1_valid_q && !s1_adv;
	assign in_fire  = in_valid && !in_stall;

	// setup names its direction, the other operations imply it
	assign in_dir    = (func == tbm_pkg::FUNC_SETUP) ? is_transmit
		: (func == tbm_pkg::FUNC_TX_READ);
	assign in_tidx   = in_dir
		? tbm_pkg::TIDX_W'(tbm_pkg::CHANNELS_PER_DIRECTION) + tbm_pkg::TIDX_W'(channel)
		: tbm_pkg::TIDX_W'(channel);
	assign in_active = (func == tbm_pkg::FUNC_SETUP || func == tbm_pkg::FUNC_RX_WRITE
		|| func == tbm_pkg::FUNC_TX_READ)
		&& (32'(channel) < tbm_pkg::CHANNELS_PER_DIRECTION);

	assign wr_en     = s1_valid_q && s1_adv && active_s1;
	assign entry_cur = byp_hit_s1 ? byp_data_s1 : rd_s1;

	tbm_entry_update u_update (
		.func         (func_s1),
		.active       (active_s1),
		.entry_in     (entry_cur),
		.acc          (acc_q),
		.channel_size (size_s1),
		.copy_size    (copy_size_q),
		.header       (header_q),
		.entry_out    (entry_new),
		.acc_next     (acc_next),
		.res          (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			copy_size_q <= '0;
			header_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				tbm_pkg::REG_COPY_SIZE: copy_size_q <= cfg_data;
				tbm_pkg::REG_HEADER:    header_q    <= cfg_data[11:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_valid_q && s1_adv) begin
				acc_q <= acc_next;
			end
			if (in_fire) begin
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= s1_valid_q;
			end
		end
	end

	// table memory: registered read at accept, write when an active stage-1 transaction retires
	always_ff @(posedge clk) begin
		if (in_fire) begin
			rd_s1 <= table_mem[in_tidx];
		end
		if (wr_en) begin
			table_mem[tidx_s1] <= entry_new;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			func_s1     <= func;
			active_s1   <= in_active;
			tidx_s1     <= in_tidx;
			size_s1     <= channel_size;
			// the retiring transaction writes the same entry this edge
			byp_hit_s1  <= wr_en && (tidx_s1 == in_tidx);
			byp_data_s1 <= entry_new;
		end
		if (s1_valid_q && s1_adv) begin
			res_q <= res_d;
		end
	end

	assign out_valid      = out_valid_q;
	assign buffer_index   = res_q.buffer_index;
	assign byte_address   = res_q.byte_address;
	assign channel_offset = res_q.channel_offset;
	assign running_total  = res_q.running_total;
	assign fresh_data     = res_q.fresh_data;

endmodule
